// File: hw/rtl/knnv_pkg.sv
package knnv_pkg;

  localparam int KNNV_MAX_NEIGHBORS = 16;
  localparam int KNNV_MAX_CLASSES   = 16;
  localparam int KNNV_DIST_WIDTH    = 16;

  localparam int DISTANCE_W  = 16;
  localparam int CLASS_W     = 4;
  localparam int ERR_W       = 16;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBORS_KEPT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] NEIGHBORS_KEPT_RESET = 5'd1;
  localparam logic [CFG_DATA_W-1:0] CLASS_COUNT_RESET    = 5'd2;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  typedef struct packed {
    logic insert;
    logic snap;
    logic count;
    logic scan;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic update;
  } vote_ctrl_t;

endpackage

// File: hw/rtl/knnv_tile_if.sv
interface knnv_tile_if;
  import knnv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DISTANCE_W-1:0] distance;
  logic [CLASS_W-1:0]    tile_class;
  logic                  last_tile;
  logic [CLASS_W-1:0]    query_label;
  logic                  last_query;

  modport source (
    output valid, distance, tile_class, last_tile, query_label, last_query,
    input  ready
  );

  modport sink (
    input  valid, distance, tile_class, last_tile, query_label, last_query,
    output ready
  );

endinterface

// File: hw/rtl/knnv_result_if.sv
interface knnv_result_if;
  import knnv_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] predicted_class;
  logic               mismatch;
  logic [ERR_W-1:0]   error_total;
  logic               batch_done;

  modport source (
    output valid, predicted_class, mismatch, error_total, batch_done,
    input  ready
  );

  modport sink (
    input  valid, predicted_class, mismatch, error_total, batch_done,
    output ready
  );

endinterface

// File: hw/rtl/knnv_cfg_if.sv
interface knnv_cfg_if;
  import knnv_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

// File: hw/rtl/knnv_cell.sv
module knnv_cell #(
  parameter int DW  = 16,
  parameter int VW  = 5,
  parameter int NCW = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  knnv_pkg::cell_ctrl_t             ctrl,
  input  logic                             active,
  input  logic [NCW-1:0]                   nc,
  input  logic [DW-1:0]                    d,
  input  logic [knnv_pkg::CLASS_W-1:0]     c,
  input  logic                             taken_in,
  input  logic [DW-1:0]                    left_dist,
  input  logic [knnv_pkg::CLASS_W-1:0]     left_cls,
  input  logic                             left_filled,
  input  logic                             rot_ok_in,
  input  logic [knnv_pkg::CLASS_W-1:0]     rot_cls_in,
  input  logic [VW-1:0]                    rot_cnt_in,
  output logic                             taken_out,
  output logic [DW-1:0]                    slot_dist,
  output logic [knnv_pkg::CLASS_W-1:0]     cls,
  output logic                             filled,
  output logic                             rot_ok,
  output logic [knnv_pkg::CLASS_W-1:0]     rot_cls,
  output logic [VW-1:0]                    rot_cnt
);
  import knnv_pkg::*;

  logic take;
  logic mine;
  logic shift;
  logic hit;

  // The first active slot that is empty or holds a larger distance takes the
  // new tile; every active slot behind it takes its left neighbor's entry.
  assign take      = active && (!filled || (slot_dist > d));
  assign mine      = take && !taken_in;
  assign shift     = active && taken_in;
  assign taken_out = taken_in || take;
  assign hit       = rot_ok && (rot_cls == cls);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (ctrl.insert) begin
      if (mine) begin
        filled <= 1'b1;
      end else if (shift) begin
        filled <= left_filled;
      end
    end else if (ctrl.snap) begin
      filled <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (mine) begin
        slot_dist <= d;
        cls       <= c;
      end else if (shift) begin
        slot_dist <= left_dist;
        cls       <= left_cls;
      end
    end else if (ctrl.snap) begin
      slot_dist <= '1;
    end
  end

  // The rotating copy circles the ring once while each slot counts the
  // voters that share its class, then the same registers drain toward the
  // tail of the chain, where the vote unit reads them, carrying the counts.
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      rot_ok  <= active && filled && (int'(cls) < int'(nc));
      rot_cls <= cls;
      rot_cnt <= '0;
    end else if (ctrl.count) begin
      rot_ok  <= rot_ok_in;
      rot_cls <= rot_cls_in;
      rot_cnt <= rot_cnt + VW'(hit);
    end else if (ctrl.scan) begin
      rot_ok  <= rot_ok_in;
      rot_cls <= rot_cls_in;
      rot_cnt <= rot_cnt_in;
    end
  end

endmodule

// File: hw/rtl/knnv_vote.sv
module knnv_vote #(
  parameter int VW = 5
) (
  input  logic                         clk,
  input  knnv_pkg::vote_ctrl_t         ctrl,
  input  logic                         cand_ok,
  input  logic [knnv_pkg::CLASS_W-1:0] cand_cls,
  input  logic [VW-1:0]                cand_cnt,
  output logic [knnv_pkg::CLASS_W-1:0] best_cls
);
  import knnv_pkg::*;

  logic [VW-1:0] best_cnt;
  logic          better;

  // More votes wins; on equal votes the lower class wins. Class 0 with no
  // votes is the starting point, so a query without voters predicts 0.
  assign better = cand_ok &&
                  ((cand_cnt > best_cnt) ||
                   ((cand_cnt == best_cnt) && (cand_cls < best_cls)));

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      best_cls <= '0;
      best_cnt <= '0;
    end else if (ctrl.update && better) begin
      best_cls <= cand_cls;
      best_cnt <= cand_cnt;
    end
  end

endmodule

// File: hw/rtl/knn_topk_vote_classifier_unit.sv
// Sequence: a tile without the last-tile mark is absorbed as it is accepted;
// after a query's last tile come snap, count (one lap of the vote ring), scan
// (one drain) and finish, which loads the result word once the output is free.
// Throughput: one tile per cycle within a query; no tile is taken until then.
// Reset: synchronous, active high; clears the slots, the error count and the
// result valid, and sets neighbors_kept to 1 and class_count to 2.
module knn_topk_vote_classifier_unit #(
  parameter int MAX_NEIGHBORS = knnv_pkg::KNNV_MAX_NEIGHBORS,
  parameter int MAX_CLASSES   = knnv_pkg::KNNV_MAX_CLASSES,
  parameter int DIST_WIDTH    = knnv_pkg::KNNV_DIST_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  knnv_tile_if.sink     tiles,
  knnv_result_if.source results,
  knnv_cfg_if.sink      cfg
);
  import knnv_pkg::*;

  localparam int N   = MAX_NEIGHBORS;
  localparam int KW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int NCW = $clog2(MAX_CLASSES + 1);
  localparam int VW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int PW  = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SNAP   = 5'b00010,
    ST_COUNT  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_DATA_W-1:0] neighbors_kept;
  logic [CFG_DATA_W-1:0] class_count;
  logic [KW-1:0]         k_eff;
  logic [NCW-1:0]        nc_eff;

  logic [PW-1:0]      phase;
  logic               phase_end;
  logic [CLASS_W-1:0] q_label;
  logic               q_last;
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   err_next;
  logic               miss;
  logic               tile_acc;
  logic               load;

  cell_ctrl_t         cctrl;
  vote_ctrl_t         vctrl;
  logic [DIST_WIDTH-1:0] d_in;
  logic [CLASS_W-1:0] best_cls;

  logic                  active   [N];
  logic                  taken    [N];
  logic [DIST_WIDTH-1:0] c_dist   [N];
  logic [CLASS_W-1:0]    c_cls    [N];
  logic                  c_filled [N];
  logic                  r_ok     [N];
  logic [CLASS_W-1:0]    r_cls    [N];
  logic [VW-1:0]         r_cnt    [N];

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbors_kept <= NEIGHBORS_KEPT_RESET;
      class_count    <= CLASS_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_NEIGHBORS_KEPT: neighbors_kept <= cfg.data;
        REG_CLASS_COUNT:    class_count    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (neighbors_kept == '0) begin
      k_eff = KW'(1);
    end else if (int'(neighbors_kept) > MAX_NEIGHBORS) begin
      k_eff = KW'(MAX_NEIGHBORS);
    end else begin
      k_eff = KW'(neighbors_kept);
    end
    if (class_count == '0) begin
      nc_eff = NCW'(1);
    end else if (int'(class_count) > MAX_CLASSES) begin
      nc_eff = NCW'(MAX_CLASSES);
    end else begin
      nc_eff = NCW'(class_count);
    end
  end

  // Sequencer.
  assign tiles.ready = (state == ST_IDLE);
  assign tile_acc    = tiles.valid && tiles.ready;
  assign phase_end   = (phase == PW'(N - 1));
  assign load        = (state == ST_FINISH) && (!results.valid || results.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (tile_acc && tiles.last_tile) state_next = ST_SNAP;
      ST_SNAP:   state_next = ST_COUNT;
      ST_COUNT:  if (phase_end) state_next = ST_SCAN;
      ST_SCAN:   if (phase_end) state_next = ST_FINISH;
      ST_FINISH: if (load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_COUNT || state == ST_SCAN) && !phase_end) begin
        phase <= phase + PW'(1);
      end else begin
        phase <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_acc && tiles.last_tile) begin
      q_label <= tiles.query_label;
      q_last  <= tiles.last_query;
    end
  end

  assign cctrl.insert = tile_acc;
  assign cctrl.snap   = (state == ST_SNAP);
  assign cctrl.count  = (state == ST_COUNT);
  assign cctrl.scan   = (state == ST_SCAN);
  assign vctrl.clear  = (state == ST_SNAP);
  assign vctrl.update = (state == ST_SCAN);
  assign d_in         = DIST_WIDTH'(tiles.distance);

  // Chain of slots, nearest at index 0.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                  t_in;
    logic [DIST_WIDTH-1:0] l_dist;
    logic [CLASS_W-1:0]    l_cls;
    logic                  l_filled;
    logic                  ro_in;
    logic [CLASS_W-1:0]    rc_in;
    logic [VW-1:0]         rn_in;

    assign active[g] = (g < int'(k_eff));

    if (g == 0) begin : g_head
      assign t_in     = 1'b0;
      assign l_dist   = '1;
      assign l_cls    = '0;
      assign l_filled = 1'b0;
      // The ring closes only while counting; while draining, empty words enter.
      assign ro_in    = cctrl.count && r_ok[N-1];
      assign rc_in    = r_cls[N-1];
      assign rn_in    = '0;
    end else begin : g_body
      assign t_in     = taken[g-1];
      assign l_dist   = c_dist[g-1];
      assign l_cls    = c_cls[g-1];
      assign l_filled = c_filled[g-1];
      assign ro_in    = r_ok[g-1];
      assign rc_in    = r_cls[g-1];
      assign rn_in    = r_cnt[g-1];
    end

    knnv_cell #(
      .DW  (DIST_WIDTH),
      .VW  (VW),
      .NCW (NCW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cctrl),
      .active      (active[g]),
      .nc          (nc_eff),
      .d           (d_in),
      .c           (tiles.tile_class),
      .taken_in    (t_in),
      .left_dist   (l_dist),
      .left_cls    (l_cls),
      .left_filled (l_filled),
      .rot_ok_in   (ro_in),
      .rot_cls_in  (rc_in),
      .rot_cnt_in  (rn_in),
      .taken_out   (taken[g]),
      .slot_dist   (c_dist[g]),
      .cls         (c_cls[g]),
      .filled      (c_filled[g]),
      .rot_ok      (r_ok[g]),
      .rot_cls     (r_cls[g]),
      .rot_cnt     (r_cnt[g])
    );
  end

  knnv_vote #(
    .VW (VW)
  ) u_vote (
    .clk      (clk),
    .ctrl     (vctrl),
    .cand_ok  (r_ok[N-1]),
    .cand_cls (r_cls[N-1]),
    .cand_cnt (r_cnt[N-1]),
    .best_cls (best_cls)
  );

  // Error count and result word.
  assign miss     = (best_cls != q_label);
  assign err_next = (miss && (err != ERR_MAX)) ? err + ERR_W'(1) : err;

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= '0;
    end else if (load) begin
      err <= q_last ? '0 : err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.predicted_class <= best_cls;
      results.mismatch        <= miss;
      results.error_total     <= err_next;
      results.batch_done      <= q_last;
    end
  end

`ifndef SYNTHESIS
  a_last_starts_vote: assert property (@(posedge clk) disable iff (rst)
    (tile_acc && tiles.last_tile) |=> (state == ST_SNAP))
    else $error("last tile did not start the vote");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (int'(phase) < N))
    else $error("phase counter out of range");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    load |=> (results.valid && state == ST_IDLE))
    else $error("finished vote did not produce a result word");

  a_err_after_batch: assert property (@(posedge clk) disable iff (rst)
    (load && q_last) |=> (err == '0))
    else $error("error count not cleared after the last query");
`endif

endmodule
